// File: src/lcpg_pkg.sv
// Shared types and constants of the LED chase pattern generator.
package lcpg_pkg;

  localparam int CFG_AW = 5;

  localparam logic [2:0] REG_BASE_COLOR = 3'd0;
  localparam logic [2:0] REG_RAMP_WIDTH = 3'd1;
  localparam logic [2:0] REG_GAP_LENGTH = 3'd2;
  localparam logic [2:0] REG_STEP_TICKS = 3'd3;
  localparam logic [2:0] REG_START_LED  = 3'd4;
  localparam logic [2:0] REG_LED_COUNT  = 3'd5;

  localparam logic [23:0] RST_BASE_COLOR = 24'd0;
  localparam logic [4:0]  RST_RAMP_WIDTH = 5'd5;
  localparam logic [6:0]  RST_GAP_LENGTH = 7'd4;
  localparam logic [15:0] RST_STEP_TICKS = 16'd100;
  localparam logic [7:0]  RST_START_LED  = 8'd0;
  localparam logic [6:0]  RST_LED_COUNT  = 7'd64;

  localparam logic [5:0] DIV_STEPS_WORD = 6'd32;
  localparam logic [5:0] DIV_STEPS_BYTE = 6'd8;

  typedef struct packed {
    logic [23:0] base_color;
    logic [4:0]  ramp_width;
    logic [6:0]  gap_length;
    logic [15:0] step_ticks;
    logic [7:0]  start_led;
    logic [6:0]  led_count;
  } cfg_t;

  // divider operand / result selection
  typedef enum logic [2:0] {
    SEL_TIME,
    SEL_MOD,
    SEL_RED,
    SEL_GRN,
    SEL_BLU
  } sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_TIME,
    S_DIV_MOD,
    S_DIV_RED,
    S_DIV_GRN,
    S_DIV_BLU,
    S_PRESET,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic div_start;
    sel_e start_sel;
    logic cap;
    sel_e cap_sel;
    logic acc_clr;
    logic acc_inc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_done;
    logic last;
    logic cnt_zero;
  } stat_t;

endpackage

// File: src/lcpg_regs.sv
// APB configuration register bank.
module lcpg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcpg_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lcpg_pkg::cfg_t              cfg_o
);
  import lcpg_pkg::*;

  cfg_t       cfg_q;
  logic       wr;
  logic [2:0] idx;

  assign idx    = paddr[CFG_AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_color <= RST_BASE_COLOR;
      cfg_q.ramp_width <= RST_RAMP_WIDTH;
      cfg_q.gap_length <= RST_GAP_LENGTH;
      cfg_q.step_ticks <= RST_STEP_TICKS;
      cfg_q.start_led  <= RST_START_LED;
      cfg_q.led_count  <= RST_LED_COUNT;
    end else if (wr) begin
      case (idx)
        REG_BASE_COLOR: cfg_q.base_color <= pwdata[23:0];
        REG_RAMP_WIDTH: cfg_q.ramp_width <= pwdata[4:0];
        REG_GAP_LENGTH: cfg_q.gap_length <= pwdata[6:0];
        REG_STEP_TICKS: cfg_q.step_ticks <= pwdata[15:0];
        REG_START_LED:  cfg_q.start_led  <= pwdata[7:0];
        REG_LED_COUNT:  cfg_q.led_count  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASE_COLOR: prdata = 32'(cfg_q.base_color);
      REG_RAMP_WIDTH: prdata = 32'(cfg_q.ramp_width);
      REG_GAP_LENGTH: prdata = 32'(cfg_q.gap_length);
      REG_STEP_TICKS: prdata = 32'(cfg_q.step_ticks);
      REG_START_LED:  prdata = 32'(cfg_q.start_led);
      REG_LED_COUNT:  prdata = 32'(cfg_q.led_count);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: src/lcpg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module lcpg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  input  logic [5:0]  steps_i,
  output logic        done_o,
  output logic [31:0] quotient_o,
  output logic [15:0] remainder_o
);

  logic [5:0]  cnt_q;
  logic        done_q;
  logic [31:0] quo_q;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dvs_q;
  logic [16:0] trial;
  logic        ge;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[31]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= steps_i;
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 6'd1;
        done_q <= (cnt_q == 6'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[30:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: src/lcpg_datapath.sv
// Datapath: pattern position, channel scaling accumulators and result registers.
module lcpg_datapath #(
  parameter int MAX_LEDS = 64,
  parameter int MAX_GAP  = 64,
  parameter int MAX_RAMP = 31
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lcpg_pkg::cfg_t  cfg_i,
  input  logic [31:0]     frame_time_i,
  input  lcpg_pkg::cmd_t  cmd_i,
  output lcpg_pkg::stat_t stat_o,
  output logic            strobe_o,
  output logic [8:0]      led_index_o,
  output logic [23:0]     pixel_color_o,
  output logic            last_pixel_o
);
  import lcpg_pkg::*;

  localparam int PIX_W = $clog2(MAX_LEDS + 1);

  typedef enum logic [1:0] {
    ACC_CLR,
    ACC_LOAD,
    ACC_INC,
    ACC_DEC
  } acc_op_e;

  // effective configuration
  logic [4:0]  ramp_sat, ramp_odd;
  logic [3:0]  half;
  logic [4:0]  den;
  logic [4:0]  peak;
  logic [6:0]  gap_eff;
  logic [7:0]  len;
  logic [15:0] st_eff;
  logic [6:0]  cnt_eff;

  always_comb begin
    ramp_sat = (32'(cfg_i.ramp_width) > MAX_RAMP) ? 5'(MAX_RAMP) : cfg_i.ramp_width;
    ramp_odd = ramp_sat | 5'd1;
    half     = ramp_odd[4:1];
    den      = {1'b0, half} + 5'd1;
    peak     = {half, 1'b1};
    gap_eff  = (32'(cfg_i.gap_length) > MAX_GAP) ? 7'(MAX_GAP) : cfg_i.gap_length;
    len      = 8'(peak) + 8'(gap_eff);
    st_eff   = (cfg_i.step_ticks == '0) ? 16'd1 : cfg_i.step_ticks;
    cnt_eff  = (32'(cfg_i.led_count) > MAX_LEDS) ? 7'(MAX_LEDS) : cfg_i.led_count;
  end

  // shared divider
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic [5:0]  div_steps;
  logic        div_done;
  logic [31:0] div_quo;
  logic [15:0] div_rem;

  always_comb begin
    case (cmd_i.start_sel)
      SEL_TIME: begin
        div_dividend = frame_time_i;
        div_divisor  = st_eff;
        div_steps    = DIV_STEPS_WORD;
      end
      SEL_MOD: begin
        div_dividend = div_quo;
        div_divisor  = 16'(len);
        div_steps    = DIV_STEPS_WORD;
      end
      SEL_RED: begin
        div_dividend = {cfg_i.base_color[23:16], 24'd0};
        div_divisor  = 16'(den);
        div_steps    = DIV_STEPS_BYTE;
      end
      SEL_GRN: begin
        div_dividend = {cfg_i.base_color[15:8], 24'd0};
        div_divisor  = 16'(den);
        div_steps    = DIV_STEPS_BYTE;
      end
      SEL_BLU: begin
        div_dividend = {cfg_i.base_color[7:0], 24'd0};
        div_divisor  = 16'(den);
        div_steps    = DIV_STEPS_BYTE;
      end
      default: begin
        div_dividend = frame_time_i;
        div_divisor  = st_eff;
        div_steps    = DIV_STEPS_WORD;
      end
    endcase
  end

  lcpg_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .steps_i     (div_steps),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // per-channel step of channel * num / den: quotient and remainder
  function automatic logic [11:0] acc_step(input acc_op_e op, input logic [7:0] q,
                                           input logic [3:0] r, input logic [7:0] a,
                                           input logic [3:0] b, input logic [4:0] d);
    logic [4:0] s;
    logic [4:0] t;
    logic [7:0] qn;
    logic [3:0] rn;
    s  = 5'(r) + 5'(b);
    t  = 5'(r) - 5'(b);
    qn = q;
    rn = r;
    case (op)
      ACC_CLR: begin
        qn = '0;
        rn = '0;
      end
      ACC_LOAD: begin
        qn = a;
        rn = b;
      end
      ACC_INC: begin
        if (s >= d) begin
          qn = q + a + 8'd1;
          rn = 4'(s - d);
        end else begin
          qn = q + a;
          rn = 4'(s);
        end
      end
      ACC_DEC: begin
        if (r < b) begin
          qn = q - a - 8'd1;
          rn = 4'(t + d);
        end else begin
          qn = q - a;
          rn = 4'(t);
        end
      end
      default: begin
        qn = q;
        rn = r;
      end
    endcase
    return {qn, rn};
  endfunction

  logic [7:0]       pos_q, pos_nx;
  logic [4:0]       num0;
  logic [4:0]       wk_q;
  logic [PIX_W-1:0] pix_q;
  logic [7:0]       a_q   [3];
  logic [3:0]       b_q   [3];
  logic [7:0]       acc_q [3];
  logic [3:0]       rq_q  [3];
  logic [11:0]      acc_nx[3];
  acc_op_e          pix_op, acc_op;
  logic             acc_en;
  logic             last;

  // brightness numerator at the first LED
  always_comb begin
    if (pos_q < 8'(half)) begin
      num0 = 5'(pos_q) + 5'd1;
    end else if (pos_q == 8'(half)) begin
      num0 = den;
    end else if (pos_q < 8'(peak)) begin
      num0 = 5'(8'(peak) - pos_q);
    end else begin
      num0 = '0;
    end
  end

  always_comb begin
    pos_nx = (pos_q == len - 8'd1) ? '0 : pos_q + 8'd1;
    if (pos_nx == '0) begin
      pix_op = ACC_LOAD;
    end else if (pos_nx <= 8'(half)) begin
      pix_op = ACC_INC;
    end else if (pos_nx < 8'(peak)) begin
      pix_op = ACC_DEC;
    end else begin
      pix_op = ACC_CLR;
    end

    if (cmd_i.acc_clr) begin
      acc_op = ACC_CLR;
    end else if (cmd_i.acc_inc) begin
      acc_op = ACC_INC;
    end else begin
      acc_op = pix_op;
    end
    acc_en = cmd_i.acc_clr || cmd_i.acc_inc || cmd_i.emit;

    for (int c = 0; c < 3; c++) begin
      acc_nx[c] = acc_step(acc_op, acc_q[c], rq_q[c], a_q[c], b_q[c], den);
    end
  end

  assign last = (7'(pix_q) == cnt_eff - 7'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      case (cmd_i.cap_sel)
        SEL_MOD: pos_q <= len - 8'd1 - div_rem[7:0];
        SEL_RED: begin
          a_q[0] <= div_quo[7:0];
          b_q[0] <= div_rem[3:0];
        end
        SEL_GRN: begin
          a_q[1] <= div_quo[7:0];
          b_q[1] <= div_rem[3:0];
        end
        SEL_BLU: begin
          a_q[2] <= div_quo[7:0];
          b_q[2] <= div_rem[3:0];
        end
        default: ;
      endcase
    end else if (cmd_i.emit) begin
      pos_q <= pos_nx;
    end

    if (acc_en) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= acc_nx[c][11:4];
        rq_q[c]  <= acc_nx[c][3:0];
      end
    end

    if (cmd_i.emit) begin
      led_index_o   <= 9'(cfg_i.start_led) + 9'(pix_q);
      pixel_color_o <= {acc_q[0], acc_q[1], acc_q[2]};
      last_pixel_o  <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
      wk_q     <= '0;
      pix_q    <= '0;
    end else begin
      strobe_o <= cmd_i.emit;
      if (cmd_i.acc_clr) begin
        wk_q  <= '0;
        pix_q <= '0;
      end else begin
        if (cmd_i.acc_inc) begin
          wk_q <= wk_q + 5'd1;
        end
        if (cmd_i.emit) begin
          pix_q <= pix_q + PIX_W'(1);
        end
      end
    end
  end

  always_comb begin
    stat_o.div_done  = div_done;
    stat_o.walk_done = (wk_q == num0);
    stat_o.last      = last;
    stat_o.cnt_zero  = (cnt_eff == '0);
  end

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_pixel_o |=> !strobe_o)
    else $error("transfer follows the last pixel of a frame");

  a_pix_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> 7'(pix_q) < cnt_eff)
    else $error("pixel counter beyond LED count");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_inc |-> wk_q < num0)
    else $error("preset walk overran its numerator");

endmodule

// File: src/lcpg_ctrl.sv
// Frame sequencer: divisions, accumulator preset and pixel emission.
module lcpg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  lcpg_pkg::stat_t stat_i,
  output lcpg_pkg::cmd_t  cmd_o
);
  import lcpg_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    busy_o          = 1'b1;
    cmd_o.div_start = 1'b0;
    cmd_o.start_sel = SEL_TIME;
    cmd_o.cap       = 1'b0;
    cmd_o.cap_sel   = SEL_TIME;
    cmd_o.acc_clr   = 1'b0;
    cmd_o.acc_inc   = 1'b0;
    cmd_o.emit      = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        // an empty segment yields nothing: drop the transfer
        if (start_i && !stat_i.cnt_zero) begin
          cmd_o.div_start = 1'b1;
          cmd_o.start_sel = SEL_TIME;
          state_d         = S_DIV_TIME;
        end
      end
      S_DIV_TIME: begin
        if (stat_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.start_sel = SEL_MOD;
          state_d         = S_DIV_MOD;
        end
      end
      S_DIV_MOD: begin
        cmd_o.cap_sel = SEL_MOD;
        if (stat_i.div_done) begin
          cmd_o.cap       = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.start_sel = SEL_RED;
          state_d         = S_DIV_RED;
        end
      end
      S_DIV_RED: begin
        cmd_o.cap_sel = SEL_RED;
        if (stat_i.div_done) begin
          cmd_o.cap       = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.start_sel = SEL_GRN;
          state_d         = S_DIV_GRN;
        end
      end
      S_DIV_GRN: begin
        cmd_o.cap_sel = SEL_GRN;
        if (stat_i.div_done) begin
          cmd_o.cap       = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.start_sel = SEL_BLU;
          state_d         = S_DIV_BLU;
        end
      end
      S_DIV_BLU: begin
        cmd_o.cap_sel = SEL_BLU;
        if (stat_i.div_done) begin
          cmd_o.cap     = 1'b1;
          cmd_o.acc_clr = 1'b1;
          state_d       = S_PRESET;
        end
      end
      S_PRESET: begin
        // advance the accumulators up to the first LED's brightness
        if (stat_i.walk_done) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.acc_inc = 1'b1;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/led_chase_pattern_generator_unit.sv
// Top level of the LED chase pattern generator.
// Sequence: divisions of time/step, the modulo and each colour channel, then a preset walk of
//   n steps, n being the first LED's brightness numerator (0 to 16); one pixel per cycle after
//   that, led_count (capped at MAX_LEDS) in all. A new frame is taken only once idle.
// Shared one-bit-a-cycle divider: 32 steps for time/step, 32 for the modulo, 8 per channel.
// Results cannot be stalled; a frame with led_count zero is taken and gives no result.
// Reset clears the sequencer and loads the register defaults; no clearing pass.
module led_chase_pattern_generator_unit #(
  parameter int MAX_LEDS = 64,
  parameter int MAX_GAP  = 64,
  parameter int MAX_RAMP = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 frame_time_i,
  output logic                        strobe_o,
  output logic [8:0]                  led_index_o,
  output logic [23:0]                 pixel_color_o,
  output logic                        last_pixel_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcpg_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lcpg_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  lcpg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lcpg_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  lcpg_datapath #(
    .MAX_LEDS (MAX_LEDS),
    .MAX_GAP  (MAX_GAP),
    .MAX_RAMP (MAX_RAMP)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .frame_time_i  (frame_time_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .strobe_o      (strobe_o),
    .led_index_o   (led_index_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule
